// ===== rtl/agc_pkg.sv =====
// ----------------------------------------------------------------------------
// agc_pkg
// Shared constants and codes of the anagram group classifier.
// ----------------------------------------------------------------------------
package agc_pkg;

	localparam int MaxLenDef     = 64;
	localparam int MaxGroupsDef  = 64;
	localparam int AlphabetDef   = 26;
	localparam int MaxMembersDef = 1023;

	localparam logic [1:0] CMD_LETTER = 2'd0;
	localparam logic [1:0] CMD_EMPTY  = 2'd1;
	localparam logic [1:0] CMD_CLEAR  = 2'd2;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_FULL    = 2'd1;
	localparam logic [1:0] ST_TOOLONG = 2'd2;

	localparam int GroupIdxCap  = 63;
	localparam int MemberIdxCap = 1023;

endpackage

// ===== rtl/agc_ram.sv =====
// ----------------------------------------------------------------------------
// agc_ram
// Generic RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module agc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/anagram_group_classifier.sv =====
// ----------------------------------------------------------------------------
// anagram_group_classifier
// Groups words by letter histogram; groups numbered by first appearance.
// ----------------------------------------------------------------------------
// channel  | handshake           | payload
// input    | start & !busy       | command, letter, word_end
// result   | done (one cycle)    | group_index, new_group, member_index, status
//
// A letter that does not end a word is accepted and busy stays low.
// A word end raises busy and walks the signature memory one entry per cycle,
// with a gap after each mismatch. Within each stored group the first mismatch
// ends the compare early. When no group matches, a full table gives status
// FULL and otherwise a new group is made. A match updates its member count,
// and a new group writes its signature one letter count at a time.
// done pulses for one cycle as busy falls. An overlong word gives done in the
// cycle after its last letter and never raises busy. The receiver cannot
// stall. Reset clears the current word and the group count.
module anagram_group_classifier #(
	parameter int MAX_LEN     = agc_pkg::MaxLenDef,
	parameter int MAX_GROUPS  = agc_pkg::MaxGroupsDef,
	parameter int ALPHABET    = agc_pkg::AlphabetDef,
	parameter int MAX_MEMBERS = agc_pkg::MaxMembersDef
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [1:0] command,
	input  logic [4:0] letter,
	input  logic       word_end,
	output logic       done,
	output logic [5:0] group_index,
	output logic       new_group,
	output logic [9:0] member_index,
	output logic [1:0] status
);
	import agc_pkg::*;

	localparam int HW   = $clog2(MAX_LEN + 1);
	localparam int LW   = (ALPHABET > 1) ? $clog2(ALPHABET) : 1;
	localparam int GW   = $clog2(MAX_GROUPS + 1);
	localparam int GIW  = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
	localparam int SD   = MAX_GROUPS * ALPHABET;
	localparam int SAW  = (SD > 1) ? $clog2(SD) : 1;
	localparam int SZW  = $clog2(MAX_MEMBERS + 1);

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_SEARCH = 2'd1;
	localparam logic [1:0] S_MEMB   = 2'd2;
	localparam logic [1:0] S_WRITE  = 2'd3;

	logic [1:0]    state_q;
	logic [HW-1:0] hist_q [ALPHABET];
	logic [HW-1:0] len_q;
	logic          ovf_q;
	logic [GW-1:0] count_q;
	logic [GW-1:0] g_q;
	logic [LW-1:0] a_q;
	logic          v_s1;
	logic [GW-1:0] g_s1;
	logic [LW-1:0] a_s1;

	logic          done_q;
	logic [5:0]    gidx_q;
	logic          newg_q;
	logic [9:0]    midx_q;
	logic [1:0]    stat_q;

	logic [LW-1:0]  hidx;
	logic [HW-1:0]  hval;
	logic [SAW-1:0] sig_raddr, sig_waddr;
	logic [HW-1:0]  sig_rdata;
	logic           sig_we;
	logic           sz_we;
	logic [GIW-1:0] sz_waddr, sz_raddr;
	logic [SZW-1:0] sz_wdata, sz_rdata;
	logic           let_ok;
	logic           sig_eq;
	logic [LW-1:0]  let_idx;

	assign busy         = (state_q != S_IDLE);
	assign done         = done_q;
	assign group_index  = gidx_q;
	assign new_group    = newg_q;
	assign member_index = midx_q;
	assign status       = stat_q;

	assign let_ok    = (32'(letter) < ALPHABET);
	assign let_idx   = LW'(letter);
	assign hidx      = (state_q == S_WRITE) ? a_q : a_s1;
	assign hval      = hist_q[hidx];
	assign sig_eq    = (sig_rdata == hval);
	assign sig_raddr = SAW'(32'(g_q) * ALPHABET + 32'(a_q));
	assign sig_waddr = SAW'(32'(count_q) * ALPHABET + 32'(a_q));
	assign sig_we    = (state_q == S_WRITE);
	assign sz_raddr  = GIW'(g_s1);

	always_comb begin
		sz_we    = 1'b0;
		sz_waddr = GIW'(count_q);
		sz_wdata = SZW'(1);
		if (state_q == S_WRITE && a_q == '0) begin
			sz_we = 1'b1;
		end else if (state_q == S_MEMB) begin
			sz_we    = (32'(sz_rdata) < MAX_MEMBERS);
			sz_waddr = GIW'(g_s1);
			sz_wdata = sz_rdata + SZW'(1);
		end
	end

	agc_ram #(.WIDTH(HW), .DEPTH(SD)) u_sig (
		.clk   (clk),
		.we    (sig_we),
		.waddr (sig_waddr),
		.wdata (hval),
		.raddr (sig_raddr),
		.rdata (sig_rdata)
	);

	agc_ram #(.WIDTH(SZW), .DEPTH(MAX_GROUPS)) u_size (
		.clk   (clk),
		.we    (sz_we),
		.waddr (sz_waddr),
		.wdata (sz_wdata),
		.raddr (sz_raddr),
		.rdata (sz_rdata)
	);

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start && command == CMD_LETTER && word_end
				&& (ovf_q || (let_ok && len_q >= HW'(MAX_LEN)))) begin
			gidx_q <= '0;
			newg_q <= 1'b0;
			midx_q <= '0;
			stat_q <= ST_TOOLONG;
		end else if (state_q == S_SEARCH && !v_s1 && g_q >= count_q) begin
			gidx_q <= '0;
			newg_q <= 1'b0;
			midx_q <= '0;
			stat_q <= ST_FULL;
		end else if (state_q == S_MEMB) begin
			gidx_q <= (32'(g_s1) > GroupIdxCap) ? 6'(GroupIdxCap) : 6'(g_s1);
			newg_q <= 1'b0;
			midx_q <= (32'(sz_rdata) > MemberIdxCap) ? 10'(MemberIdxCap) : 10'(sz_rdata);
			stat_q <= ST_OK;
		end else if (state_q == S_WRITE) begin
			gidx_q <= (32'(count_q) > GroupIdxCap) ? 6'(GroupIdxCap) : 6'(count_q);
			newg_q <= 1'b1;
			midx_q <= '0;
			stat_q <= ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			for (int i = 0; i < ALPHABET; i++) hist_q[i] <= '0;
			len_q   <= '0;
			ovf_q   <= 1'b0;
			count_q <= '0;
			g_q     <= '0;
			a_q     <= '0;
			v_s1    <= 1'b0;
			g_s1    <= '0;
			a_s1    <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			v_s1   <= 1'b0;
			case (state_q)
				S_IDLE: begin
					g_q <= '0;
					a_q <= '0;
					if (start) begin
						case (command)
							CMD_CLEAR: begin
								count_q <= '0;
								for (int i = 0; i < ALPHABET; i++) hist_q[i] <= '0;
								len_q <= '0;
								ovf_q <= 1'b0;
							end
							CMD_EMPTY: begin
								for (int i = 0; i < ALPHABET; i++) hist_q[i] <= '0;
								len_q   <= '0;
								ovf_q   <= 1'b0;
								state_q <= S_SEARCH;
							end
							CMD_LETTER: begin
								if (word_end && (ovf_q
										|| (let_ok && len_q >= HW'(MAX_LEN)))) begin
									for (int i = 0; i < ALPHABET; i++) hist_q[i] <= '0;
									len_q  <= '0;
									ovf_q  <= 1'b0;
									done_q <= 1'b1;
								end else begin
									if (let_ok) begin
										if (len_q >= HW'(MAX_LEN)) begin
											ovf_q <= 1'b1;
										end else begin
											hist_q[let_idx] <= hist_q[let_idx] + HW'(1);
											len_q <= len_q + HW'(1);
										end
									end
									if (word_end) begin
										state_q <= S_SEARCH;
									end
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_SEARCH: begin
					if (v_s1 && !sig_eq) begin
						g_q <= g_s1 + GW'(1);
						a_q <= '0;
					end else if (v_s1 && 32'(a_s1) == ALPHABET - 1) begin
						state_q <= S_MEMB;
					end else if (g_q < count_q) begin
						v_s1 <= 1'b1;
						g_s1 <= g_q;
						a_s1 <= a_q;
						if (32'(a_q) == ALPHABET - 1) begin
							a_q <= '0;
							g_q <= g_q + GW'(1);
						end else begin
							a_q <= a_q + LW'(1);
						end
					end else if (!v_s1) begin
						if (32'(count_q) >= MAX_GROUPS) begin
							for (int i = 0; i < ALPHABET; i++) hist_q[i] <= '0;
							len_q   <= '0;
							ovf_q   <= 1'b0;
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end else begin
							a_q     <= '0;
							state_q <= S_WRITE;
						end
					end
				end
				S_MEMB: begin
					for (int i = 0; i < ALPHABET; i++) hist_q[i] <= '0;
					len_q   <= '0;
					ovf_q   <= 1'b0;
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				S_WRITE: begin
					if (32'(a_q) == ALPHABET - 1) begin
						for (int i = 0; i < ALPHABET; i++) hist_q[i] <= '0;
						len_q   <= '0;
						ovf_q   <= 1'b0;
						count_q <= count_q + GW'(1);
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						a_q <= a_q + LW'(1);
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== rtl/agc_checker.sv =====
// ----------------------------------------------------------------------------
// agc_checker
// Port-level checks of the anagram group classifier, bound to the top level.
// ----------------------------------------------------------------------------
module agc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic [1:0] command,
	input logic [4:0] letter,
	input logic       word_end,
	input logic       done,
	input logic [5:0] group_index,
	input logic       new_group,
	input logic [9:0] member_index,
	input logic [1:0] status
);
	import agc_pkg::*;

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (status == ST_OK || status == ST_FULL || status == ST_TOOLONG))
		else $error("bad status code");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != ST_OK) |-> (group_index == 0 && !new_group && member_index == 0))
		else $error("failed transaction carries nonzero fields");

	a_new_first: assert property (@(posedge clk) disable iff (!arst_n)
		(done && new_group) |-> (member_index == 0))
		else $error("new group with nonzero member index");

	a_clear_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && command == CMD_CLEAR) |=> !done)
		else $error("clear produced a result");

endmodule

bind anagram_group_classifier agc_checker u_agc_checker (.*);
